>>> rtl/pbmm_pkg.sv
// Package for the push-button motor mode control block.
// Holds the counter width, the mode codes and the register map; no dependencies.

package pbmm_pkg;

  // Width of the hold counter.
  localparam int COUNT_BITS = 16;

  // Width of the long press threshold register.
  localparam int TICKS_BITS = 16;

  // Common width for comparing the counter against the threshold.
  localparam int CMP_BITS = (COUNT_BITS > TICKS_BITS) ? COUNT_BITS : TICKS_BITS;

  // Mode codes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CONT   = 2'd1;
  localparam logic [1:0] MODE_MOMENT = 2'd2;

  // Configuration port.
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic REG_LONG_PRESS_TICKS = 1'b0;
  localparam logic [TICKS_BITS-1:0] LONG_PRESS_RESET = TICKS_BITS'(100);

endpackage

>>> rtl/push_button_motor_mode_control_unit.sv
// Top level of the push-button motor mode control block.
// Depends on pbmm_pkg for the counter width, mode codes and register map.
//
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-------------------------------------------
// in_     | input     | in_valid / in_stall   | in_button_pressed
// out_    | output    | out_valid / out_stall | out_drive_a, out_drive_b, out_mode_now,
//         |           |                       | out_direction_now
// cfg     | input     | psel / penable        | paddr, pwdata, prdata (long_press_ticks)
//
// One request is taken per cycle while in_stall is low; each produces one result
// through an input register and a result register. The mode update is a
// single pass of compare and select logic between those two registers.
// Reset (rst_n low, synchronous) empties both stages and restores the mode
// state and the threshold of 100 ticks. A stalled result holds the pipeline:
// one further request can wait in the input register before in_stall rises.

module push_button_motor_mode_control_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_button_pressed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_drive_a,
  output logic                            out_drive_b,
  output logic [1:0]                      out_mode_now,
  output logic                            out_direction_now,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbmm_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [pbmm_pkg::DATA_BITS-1:0]  pwdata,
  output logic [pbmm_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import pbmm_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration register.
  logic [TICKS_BITS-1:0] long_press_r;

  // Input stage.
  logic in_valid_r;
  logic in_button_r;

  // Mode state.
  logic [1:0]            mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] hold_r, hold_nxt;
  logic                  latch_r, latch_nxt;
  logic                  dir_r, dir_nxt;

  // Result stage.
  logic       out_valid_r;
  logic       drive_a_r, drive_a_nxt;
  logic       drive_b_r, drive_b_nxt;
  logic [1:0] mode_out_r;
  logic       dir_out_r;

  logic out_move;
  logic in_take;
  logic [COUNT_BITS-1:0] hold_inc;
  logic                  at_threshold;

  // Pipeline control: the result register frees up when empty or taken.
  assign out_move = ~out_valid_r | ~out_stall;
  assign in_stall = in_valid_r & ~out_move;
  assign in_take  = in_valid & ~in_stall;

  // APB register access.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LONG_PRESS_TICKS) ?
                  DATA_BITS'(long_press_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= LONG_PRESS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_LONG_PRESS_TICKS) begin
      long_press_r <= pwdata[TICKS_BITS-1:0];
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (out_move) begin
      in_valid_r <= in_take;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_button_r <= in_button_pressed;
    end
  end

  // Pin drive from the mode and direction before the update.
  always_comb begin
    drive_a_nxt = 1'b0;
    drive_b_nxt = 1'b0;
    if (mode_r == MODE_CONT || mode_r == MODE_MOMENT) begin
      drive_a_nxt = dir_r;
      drive_b_nxt = ~dir_r;
    end
  end

  // Saturating hold count and the threshold compare.
  assign hold_inc     = (hold_r != COUNT_MAX) ? hold_r + 1'b1 : hold_r;
  assign at_threshold = CMP_BITS'(hold_inc) >= CMP_BITS'(long_press_r);

  // Mode machine update.
  always_comb begin
    mode_nxt  = mode_r;
    hold_nxt  = hold_r;
    latch_nxt = latch_r;
    dir_nxt   = dir_r;
    case (mode_r)
      MODE_OFF, MODE_CONT: begin
        if (in_button_r) begin
          hold_nxt = hold_inc;
          if (at_threshold) begin
            mode_nxt = MODE_MOMENT;
          end else if (!latch_r) begin
            latch_nxt = 1'b1;
            mode_nxt  = (mode_r == MODE_OFF) ? MODE_CONT : MODE_OFF;
          end
        end else if (latch_r) begin
          hold_nxt  = '0;
          latch_nxt = 1'b0;
        end
      end
      MODE_MOMENT: begin
        // Release ends the momentary run and flips the direction.
        if (!in_button_r) begin
          hold_nxt  = '0;
          latch_nxt = 1'b0;
          mode_nxt  = MODE_OFF;
          dir_nxt   = ~dir_r;
        end
      end
      default: begin
        // The unused code holds every state bit.
      end
    endcase
  end

  // State registers advance when a request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OFF;
      hold_r  <= '0;
      latch_r <= 1'b0;
      dir_r   <= 1'b0;
    end else if (in_valid_r && out_move) begin
      mode_r  <= mode_nxt;
      hold_r  <= hold_nxt;
      latch_r <= latch_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_move) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && out_move) begin
      drive_a_r  <= drive_a_nxt;
      drive_b_r  <= drive_b_nxt;
      mode_out_r <= mode_r;
      dir_out_r  <= dir_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive_a       = drive_a_r;
  assign out_drive_b       = drive_b_r;
  assign out_mode_now      = mode_out_r;
  assign out_direction_now = dir_out_r;

endmodule

>>> rtl/pbmm_checker.sv
// Port-level checks for the push-button motor mode control block.
// Depends on pbmm_pkg for the mode codes; bound to the top level below.

module pbmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_drive_a,
  input logic       out_drive_b,
  input logic [1:0] out_mode_now,
  input logic       out_direction_now
);
  import pbmm_pkg::*;

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays and holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_a) &&
      $stable(out_drive_b) && $stable(out_mode_now) && $stable(out_direction_now))
    else $error("stalled result changed");

  // The bridge is never driven from both sides.
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_a && out_drive_b))
    else $error("both motor pins high");

  // Off mode leaves the motor unpowered.
  a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_now == MODE_OFF |-> !out_drive_a && !out_drive_b)
    else $error("motor driven in off mode");

  // A running mode drives the pin that matches the reported direction.
  a_run_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_mode_now == MODE_CONT || out_mode_now == MODE_MOMENT) |->
      out_drive_a == out_direction_now && out_drive_b == !out_direction_now)
    else $error("drive pins disagree with direction");

endmodule

bind push_button_motor_mode_control_unit pbmm_checker u_pbmm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_drive_a       (out_drive_a),
  .out_drive_b       (out_drive_b),
  .out_mode_now      (out_mode_now),
  .out_direction_now (out_direction_now)
);
